[rtl/core/smoa_pkg.sv]
// Shared constants for the sliding median outlier alert block.
package smoa_pkg;

  localparam int WINDOW_MAX_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Window length register
  localparam int               CFG_W     = 6;
  localparam logic [CFG_W-1:0] LEN_RESET = 6'd32;

  // Alert counter
  localparam int ALERT_W = 32;

endpackage

[rtl/core/smoa_sorter.sv]
// Sorted window cells with age tags: median taps and a combined insert/evict per push.
module smoa_sorter
  import smoa_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CNT_W = $clog2(WINDOW_MAX + 1),
  localparam int IDX_W = $clog2(WINDOW_MAX)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [CNT_W-1:0]       len_i,
  input  logic                   clear_i,
  input  logic                   push_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   full_o,
  output logic [SAMPLE_BITS:0]   twice_o
);

  logic [SAMPLE_BITS-1:0] cell_q [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] cell_d [WINDOW_MAX];
  logic [IDX_W-1:0]       age_q  [WINDOW_MAX];
  logic [IDX_W-1:0]       age_d  [WINDOW_MAX];
  logic [CNT_W-1:0]       count_q, count_d;

  logic [WINDOW_MAX-1:0] valid, rm, keep, gt;
  logic [WINDOW_MAX-1:0] from_mid, from_lo, from_hi;
  logic [CNT_W-1:0]      r_idx;
  logic [IDX_W-1:0]      evict_age;
  logic [IDX_W-1:0]      lo_idx, hi_idx;

  assign full_o    = (count_q >= len_i);
  assign evict_age = IDX_W'(len_i - 1'b1);
  assign lo_idx    = IDX_W'((len_i - 1'b1) >> 1);
  assign hi_idx    = IDX_W'(len_i >> 1);
  assign twice_o   = {1'b0, cell_q[lo_idx]} + {1'b0, cell_q[hi_idx]};

  // Classify cells: live, evicted (oldest when full), greater than the new sample
  always_comb begin
    r_idx = '0;
    for (int j = 0; j < WINDOW_MAX; j++) begin
      valid[j] = (CNT_W'(j) < count_q);
      rm[j]    = full_o && valid[j] && (age_q[j] == evict_age);
      keep[j]  = valid[j] && !rm[j];
      gt[j]    = (cell_q[j] > sample_i);
      r_idx    = r_idx | (rm[j] ? CNT_W'(j) : CNT_W'(0));
    end
    // while filling, nothing is evicted: put the hole past the live cells
    if (!full_o) begin
      r_idx = count_q;
    end
  end

  // Past the hole, cells <= sample move down one; before it, cells > sample up one
  always_comb begin
    from_lo = '0;
    from_hi = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      from_mid[i] = keep[i] && (((CNT_W'(i) < r_idx) && !gt[i]) ||
                                ((CNT_W'(i) > r_idx) && gt[i]));
    end
    for (int i = 1; i < WINDOW_MAX; i++) begin
      from_lo[i] = keep[i-1] && (CNT_W'(i - 1) < r_idx) && gt[i-1];
    end
    for (int i = 0; i < WINDOW_MAX - 1; i++) begin
      from_hi[i] = keep[i+1] && (CNT_W'(i + 1) > r_idx) && !gt[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      cell_d[i] = from_mid[i] ? cell_q[i] : sample_i;
      age_d[i]  = from_mid[i] ? age_q[i] + 1'b1 : '0;
    end
    for (int i = 1; i < WINDOW_MAX; i++) begin
      if (from_lo[i]) begin
        cell_d[i] = cell_q[i-1];
        age_d[i]  = age_q[i-1] + 1'b1;
      end
    end
    for (int i = 0; i < WINDOW_MAX - 1; i++) begin
      if (from_hi[i]) begin
        cell_d[i] = cell_q[i+1];
        age_d[i]  = age_q[i+1] + 1'b1;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (push_i && !full_o) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        cell_q[i] <= cell_d[i];
        age_q[i]  <= age_d[i];
      end
    end
  end

endmodule

[rtl/core/sliding_median_outlier_alert.sv]
// Top level of the sliding median outlier alert block.
//
// Usage: samples enter on the s_axis stream, one word per sample; each
// accepted sample yields exactly one result word on the m_axis stream.
// The cfg channel writes window_length (always ready); a write empties the
// window but keeps the alert count. Write it only while the block is idle.
// The first window_length samples only fill the window (window_ready = 0);
// afterwards each sample is compared against twice the median of the
// previous window_length samples before it replaces the oldest one.
// Output: each result word is registered before it reaches m_axis.
// Throughput: one sample per cycle while s_axis_tready_o is high; the sorted cell array inserts the new
// sample and evicts the oldest in the same cycle, by parallel compares.
// Stall: the result register plus a one-word skid buffer hold results while
// m_axis_tready_i is low; s_axis_tready_o drops only when the skid is full.
// Reset: window empty, alert count zero, window_length back to 32, both
// output words empty.
module sliding_median_outlier_alert
  import smoa_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int RAW_W = 2 + (SAMPLE_BITS + 1) + ALERT_W,
  localparam int OUT_W = ((RAW_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,      // window_length
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,  // sample, zero pad
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o   // window_ready, alert, twice_median,
                                            // alert_total, zero pad
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic [CFG_W-1:0]       wlen_q;
  logic [31:0]            len_full;
  logic [CNT_W-1:0]       len;
  logic                   cfg_wr, accept;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   full;
  logic [SAMPLE_BITS:0]   twice, twice_res;
  logic                   alert;
  logic [ALERT_W-1:0]     cnt_q, cnt_d;
  logic [OUT_W-1:0]       res_word;
  logic [OUT_W-1:0]       out_q, skid_q;
  logic                   out_valid_q, skid_valid_q;
  logic                   pop;

  assign cfg_ready_o     = 1'b1;
  assign cfg_wr          = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign sample          = s_axis_tdata_i[SAMPLE_BITS-1:0];

  // Clamp the written length into 1..WINDOW_MAX
  always_comb begin
    len_full = 32'(wlen_q);
    if (wlen_q == '0) begin
      len_full = 32'd1;
    end else if (len_full > 32'(WINDOW_MAX)) begin
      len_full = 32'(WINDOW_MAX);
    end
  end
  assign len = CNT_W'(len_full);

  smoa_sorter #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_sorter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .len_i   (len),
    .clear_i (cfg_wr),
    .push_i  (accept),
    .sample_i(sample),
    .full_o  (full),
    .twice_o (twice)
  );

  assign twice_res = full ? twice : '0;
  assign alert     = full && ({1'b0, sample} >= twice);

  // Saturate the alert count
  always_comb begin
    cnt_d = cnt_q;
    if (accept && alert && (cnt_q != '1)) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    res_word            = '0;
    res_word[RAW_W-1:0] = {cnt_d, twice_res, alert, full};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= LEN_RESET;
      cnt_q  <= '0;
    end else begin
      if (cfg_wr) begin
        wlen_q <= cfg_data_i;
      end
      cnt_q <= cnt_d;
    end
  end

  // Output register with one-word skid buffer
  assign pop = out_valid_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_word;
      end
    end else if (accept) begin
      skid_q <= res_word;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // Assertions
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  a_alert_needs_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |->
      (!m_axis_tdata_o[1] && (m_axis_tdata_o[SAMPLE_BITS+2:2] == '0)))
    else $error("alert or median reported without a full window");

  a_count_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '1) |=> (cnt_q == '1))
    else $error("saturated alert count changed");

endmodule
